>>> src/lle_pkg.sv
// shared types and constants for the life-like automaton engine
`default_nettype none

package lle_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;

	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int SIZE_W  = 7;
	localparam int MASK_W  = 9;
	localparam int CNT_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 9;

	// function codes
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_STEP  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIRTH_MASK    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SURVIVAL_MASK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd3;

	typedef struct packed {
		logic [1:0]       func;
		logic [ROW_W-1:0] cell_row;
		logic [COL_W-1:0] cell_column;
		logic             write_value;
	} cell_item_t;

	typedef struct packed {
		logic             read_value;
		logic [CNT_W-1:0] generation_count;
	} cell_result_t;

endpackage

`default_nettype wire

>>> src/life_like_automaton_engine_top.sv
// life-like automaton engine: toroidal cell grid with write, read and generation step
//
//  channel   signals                          handshake
//  --------  -------------------------------  ----------------------------------------
//  item in   start, busy, item                taken when start is high and busy is low
//  result    done, result                     one-cycle strobe, cannot be held off
//  config    cfg_write, cfg_index, cfg_data   written on any edge with cfg_write high
//
//  a cell write or read goes through a row read, then a row update, before done
//  a generation step makes MAX_HEIGHT + 2 row reads through the single
//  read port of the cell memory, one row a cycle, then writes the last row
//  and gives the result strobe
//  busy drops as the result strobe rises; one item is in the block at a time
//  reset clears every cell at once through per-row valid bits, so there is no clearing pass
`default_nettype none

module life_like_automaton_engine_top
	import lle_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire cell_item_t            item,
	output logic                       done,
	output cell_result_t               result,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int MEM_DEPTH  = 2 * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int STEP_READS = MAX_HEIGHT + 2;
	localparam int K_W        = $clog2(STEP_READS);
	localparam logic [K_W-1:0] K_LAST = K_W'(STEP_READS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL_RD,
		ST_CELL_WR,
		ST_STEP,
		ST_STEP_END
	} state_t;

	// next row of the grid from a three-row window; columns beyond the width keep their value
	function automatic logic [MAX_WIDTH-1:0] life_row(
		input logic [MAX_WIDTH-1:0] above,
		input logic [MAX_WIDTH-1:0] mid,
		input logic [MAX_WIDTH-1:0] below,
		input logic [SIZE_W-1:0]    w,
		input logic [MASK_W-1:0]    birth,
		input logic [MASK_W-1:0]    surv
	);
		logic [MAX_WIDTH-1:0] nxt;
		logic [COL_W-1:0]     wm1;
		logic [COL_W-1:0]     cl;
		logic [COL_W-1:0]     cr;
		logic                 al, ar, ml, mr, bl, br;
		logic [3:0]           cnt;
		wm1 = COL_W'(w - SIZE_W'(1));
		nxt = mid;
		for (int c = 0; c < MAX_WIDTH; c++) begin
			cl = COL_W'(c) - COL_W'(1);
			cr = COL_W'(c) + COL_W'(1);
			// left wraps to the last column in use, right wraps to column zero
			al = (c == 0) ? above[wm1] : above[cl];
			ml = (c == 0) ? mid[wm1]   : mid[cl];
			bl = (c == 0) ? below[wm1] : below[cl];
			ar = (COL_W'(c) == wm1) ? above[0] : above[cr];
			mr = (COL_W'(c) == wm1) ? mid[0]   : mid[cr];
			br = (COL_W'(c) == wm1) ? below[0] : below[cr];
			cnt = 4'(al) + 4'(above[c]) + 4'(ar) + 4'(ml) + 4'(mr)
			    + 4'(bl) + 4'(below[c]) + 4'(br);
			if (SIZE_W'(c) < w) begin
				nxt[c] = mid[c] ? surv[cnt] : birth[cnt];
			end
		end
		return nxt;
	endfunction

	// configuration registers
	logic [MASK_W-1:0] birth_mask_q;
	logic [MASK_W-1:0] survival_mask_q;
	logic [SIZE_W-1:0] grid_width_q;
	logic [SIZE_W-1:0] grid_height_q;

	// sequencer and result state
	state_t           state_q;
	cell_item_t       item_q;
	logic             bank_q;
	logic [CNT_W-1:0] gen_q;
	logic [K_W-1:0]   k_q;
	logic             done_q;
	cell_result_t     result_q;

	// read pipeline stage and row window
	logic                 vld_s1;
	logic [K_W-1:0]       k_s1;
	logic [MAX_WIDTH-1:0] win_a_q;
	logic [MAX_WIDTH-1:0] win_b_q;

	// cell memory: both banks, one write and one read port, registered read data
	logic [MAX_WIDTH-1:0] mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] row_valid_q;
	logic [MAX_WIDTH-1:0] rdata_q;
	logic                 rvalid_q;

	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [MAX_WIDTH-1:0] mem_wdata;
	logic [ADDR_W-1:0]    mem_raddr;
	logic [MAX_WIDTH-1:0] rd_row;

	logic [SIZE_W-1:0]    w_eff;
	logic [SIZE_W-1:0]    h_eff;
	logic                 in_grid;
	logic [SIZE_W-1:0]    step_idx;
	logic [SIZE_W-1:0]    k_ext;
	logic [SIZE_W-1:0]    k_s1_ext;
	logic [ROW_W-1:0]     wr_row_s1;
	logic [MAX_WIDTH-1:0] new_row;
	logic [MAX_WIDTH-1:0] cell_wr_row;

	// sizes in use: zero acts as one, anything above the maximum acts as the maximum
	always_comb begin
		if (grid_width_q == '0) begin
			w_eff = SIZE_W'(1);
		end else if (grid_width_q > SIZE_W'(MAX_WIDTH)) begin
			w_eff = SIZE_W'(MAX_WIDTH);
		end else begin
			w_eff = grid_width_q;
		end
		if (grid_height_q == '0) begin
			h_eff = SIZE_W'(1);
		end else if (grid_height_q > SIZE_W'(MAX_HEIGHT)) begin
			h_eff = SIZE_W'(MAX_HEIGHT);
		end else begin
			h_eff = grid_height_q;
		end
	end

	assign in_grid = (SIZE_W'(item_q.cell_row) < h_eff) && (SIZE_W'(item_q.cell_column) < w_eff);

	// rows never written read as dead
	assign rd_row = rvalid_q ? rdata_q : '0;

	// step read order: last row, rows 0 .. h-1, row 0 again, then rows h .. max for the copy
	assign k_ext = SIZE_W'(k_q);
	always_comb begin
		if (k_q == '0) begin
			step_idx = h_eff - SIZE_W'(1);
		end else if (k_ext == h_eff + SIZE_W'(1)) begin
			step_idx = '0;
		end else if (k_ext <= h_eff) begin
			step_idx = k_ext - SIZE_W'(1);
		end else begin
			step_idx = k_ext - SIZE_W'(2);
		end
	end

	assign k_s1_ext  = SIZE_W'(k_s1);
	assign wr_row_s1 = ROW_W'(k_s1_ext - SIZE_W'(2));
	assign new_row   = life_row(win_a_q, win_b_q, rd_row, w_eff, birth_mask_q, survival_mask_q);

	always_comb begin
		cell_wr_row = rd_row;
		cell_wr_row[item_q.cell_column] = item_q.write_value;
	end

	// memory port control
	always_comb begin
		mem_raddr = {bank_q, ROW_W'(step_idx)};
		if (state_q == ST_CELL_RD || state_q == ST_IDLE) begin
			mem_raddr = {bank_q, item_q.cell_row};
		end
		mem_we    = 1'b0;
		mem_waddr = {bank_q, item_q.cell_row};
		mem_wdata = cell_wr_row;
		if (state_q == ST_CELL_WR) begin
			mem_we = (item_q.func == FUNC_WRITE) && in_grid;
		end else if (vld_s1 && k_s1 >= K_W'(2)) begin
			// computed rows inside the grid, plain copies for rows beyond it
			mem_we    = 1'b1;
			mem_waddr = {~bank_q, wr_row_s1};
			mem_wdata = (k_s1_ext <= h_eff + SIZE_W'(1)) ? new_row : rd_row;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
		end else begin
			if (mem_we) begin
				row_valid_q[mem_waddr] <= 1'b1;
			end
			rvalid_q <= row_valid_q[mem_raddr];
		end
	end

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_mask_q    <= MASK_W'(8);
			survival_mask_q <= MASK_W'(12);
			grid_width_q    <= SIZE_W'(MAX_WIDTH);
			grid_height_q   <= SIZE_W'(MAX_HEIGHT);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BIRTH_MASK:    birth_mask_q    <= cfg_data;
				REG_SURVIVAL_MASK: survival_mask_q <= cfg_data;
				REG_GRID_WIDTH:    grid_width_q    <= SIZE_W'(cfg_data);
				REG_GRID_HEIGHT:   grid_height_q   <= SIZE_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// row window: shifts one row per returned read during a step
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			win_a_q <= win_b_q;
			win_b_q <= rd_row;
		end
	end

	// sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			item_q   <= '0;
			bank_q   <= 1'b0;
			gen_q    <= '0;
			k_q      <= '0;
			k_s1     <= '0;
			vld_s1   <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == ST_STEP);
			k_s1   <= k_q;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						item_q <= item;
						k_q    <= '0;
						state_q <= (item.func == FUNC_STEP) ? ST_STEP : ST_CELL_RD;
					end
				end
				ST_CELL_RD: begin
					state_q <= ST_CELL_WR;
				end
				ST_CELL_WR: begin
					done_q <= 1'b1;
					result_q.read_value <= (item_q.func == FUNC_READ) && in_grid
						&& rd_row[item_q.cell_column];
					result_q.generation_count <= gen_q;
					state_q <= ST_IDLE;
				end
				ST_STEP: begin
					k_q <= k_q + K_W'(1);
					if (k_q == K_LAST) begin
						state_q <= ST_STEP_END;
					end
				end
				ST_STEP_END: begin
					// last row is written this cycle; the new bank takes over
					bank_q <= ~bank_q;
					gen_q  <= gen_q + CNT_W'(1);
					done_q <= 1'b1;
					result_q.read_value       <= 1'b0;
					result_q.generation_count <= gen_q + CNT_W'(1);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

>>> src/lle_checker.sv
// port-level checks for the life-like automaton engine, bound to the top level
`default_nettype none

module lle_checker
	import lle_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  done,
	input wire cell_result_t          result
);

	// an accepted item always makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item accepted but block not busy");

	// a result only comes at the end of busy work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// the result strobe never comes back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// the result holds between strobes
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(result))
		else $error("result changed without a strobe");

endmodule

bind life_like_automaton_engine_top lle_checker u_lle_checker (.*);

`default_nettype wire
